/* sv/frq_pkg.sv */
// Frame reorder queue package: request, status and frame type codes,
// the stored slot record, controller command/status structs and the plan function.
// No dependencies.
`timescale 1ns / 1ps

package frq_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NONE  = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_REJECT    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FT_I = 2'd0,
        FT_P = 2'd1,
        FT_B = 2'd2
    } frame_kind_t;

    localparam logic [1:0] MAX_B_LIMIT = 2'd2;

    typedef struct packed {
        logic [15:0]        handle;
        logic [23:0]        size;
        logic signed [63:0] pts;
        logic signed [63:0] duration;
        logic [31:0]        disp;
        logic               forced;
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    latch_req;
        logic    set_status;
        status_t status;
        logic    push_write;
        logic    scan_init;
        logic    scan_rd;
        logic    capture;
        logic    take_restart;
        logic    k_inc;
        logic    shift_rd;
        logic    shift_wr;
        logic    count_dec;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        req_code_t req_code;
        logic      push_ok;
        logic      none_ready;
        logic      take_hit;
        logic      scan_last;
        logic      shift_done;
        logic      out_free;
    } dp_stat_t;

    function automatic frame_kind_t plan_type(slot_t s, logic [1:0] max_b);
        frame_kind_t kind;
        if (s.forced || s.disp == 32'd0)
        begin
            kind = FT_I;
        end
        else if (max_b == 2'd0)
        begin
            kind = FT_P;
        end
        else if (s.disp[0])
        begin
            kind = FT_B;
        end
        else
        begin
            kind = FT_P;
        end
        return kind;
    endfunction

endpackage

/* sv/frq_req_if.sv */
// Request channel of the frame reorder queue: valid/ready plus request payload.
// No dependencies.
`timescale 1ns / 1ps

interface frq_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [15:0]        frame_handle;
    logic [23:0]        frame_size;
    logic signed [63:0] pts;
    logic signed [63:0] duration;
    logic               force_key;

    modport source (output valid, output req_type, output frame_handle, output frame_size,
                    output pts, output duration, output force_key, input ready);
    modport sink (input valid, input req_type, input frame_handle, input frame_size,
                  input pts, input duration, input force_key, output ready);
endinterface

/* sv/frq_rsp_if.sv */
// Result channel of the frame reorder queue: valid/ready plus planned frame record.
// No dependencies.
`timescale 1ns / 1ps

interface frq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [15:0]        out_handle;
    logic [23:0]        out_size;
    logic signed [63:0] out_pts;
    logic signed [63:0] out_duration;
    logic [31:0]        out_display_index;
    logic [1:0]         frame_type;
    logic               ref_frame;
    logic [31:0]        anchor_disp;
    logic               out_forced;

    modport source (output valid, output status, output out_handle, output out_size,
                    output out_pts, output out_duration, output out_display_index,
                    output frame_type, output ref_frame, output anchor_disp,
                    output out_forced, input ready);
    modport sink (input valid, input status, input out_handle, input out_size,
                  input out_pts, input out_duration, input out_display_index,
                  input frame_type, input ref_frame, input anchor_disp,
                  input out_forced, output ready);
endinterface

/* sv/frq_cfg_if.sv */
// Configuration write channel of the frame reorder queue (max_b_frames).
// No dependencies.
`timescale 1ns / 1ps

interface frq_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/frame_reorder_queue.sv */
// Frame reorder queue top level: controller plus datapath on handshake channels.
// Depends on frq_pkg, frq_req_if, frq_rsp_if, frq_cfg_if, frq_ctrl, frq_dp.
//
// Usage:
//   req  - one request per handshake: push, pop or flush with the frame record.
//   rsp  - exactly one result per request, in request order.
//   cfg  - writes max_b_frames (clamped to 0..2); always ready, write only when idle.
// One request is handled at a time. A push writes the frame into the next free
// slot; a reject or nothing-ready answer goes straight to the result. A pop or flush
// reads the slots in order until it finds a frame not planned as B (a flush with
// only B frames queued scans again and takes the first), then moves the later
// entries down to close the gap; a pop that finds only B frames answers not ready.
// The slot memory has one write port and one read port with registered data.
// The result is loaded into an output register as the controller returns to
// idle; the controller waits before loading only if the previous result has not
// yet been taken, so a stalled receiver holds req ready low until its result is
// taken. Reset empties the queue, clears the display counter and max_b_frames;
// slot contents are not cleared and need no pass.
`timescale 1ns / 1ps

module frame_reorder_queue #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic     clk,
    input  logic     rst_n,
    frq_req_if.sink  req,
    frq_rsp_if.source rsp,
    frq_cfg_if.sink  cfg
);
    import frq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    frq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    frq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .req_type          (req.req_type),
        .frame_handle      (req.frame_handle),
        .frame_size        (req.frame_size),
        .pts               (req.pts),
        .duration          (req.duration),
        .force_key         (req.force_key),
        .cfg_valid         (cfg.valid),
        .cfg_data          (cfg.data),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .status            (rsp.status),
        .out_handle        (rsp.out_handle),
        .out_size          (rsp.out_size),
        .out_pts           (rsp.out_pts),
        .out_duration      (rsp.out_duration),
        .out_display_index (rsp.out_display_index),
        .frame_type        (rsp.frame_type),
        .ref_frame         (rsp.ref_frame),
        .anchor_disp       (rsp.anchor_disp),
        .out_forced        (rsp.out_forced)
    );

endmodule

/* sv/frq_ctrl.sv */
// Frame reorder queue controller: sequences push, scan and shift per request.
// Depends on frq_pkg.
`timescale 1ns / 1ps

module frq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  frq_pkg::dp_stat_t stat,
    output frq_pkg::dp_cmd_t  cmd
);
    import frq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.req_code == REQ_PUSH)
                begin
                    if (stat.push_ok)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_REJECT;
                        state_next     = S_DONE;
                    end
                end
                else if (stat.req_code == REQ_NONE || stat.none_ready)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_READY;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_PUSH:
            begin
                cmd.push_write = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_OK;
                state_next     = S_DONE;
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (stat.take_hit)
                begin
                    cmd.capture    = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    state_next     = S_SHIFT_RD;
                end
                else if (stat.scan_last)
                begin
                    if (stat.req_code == REQ_POP)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_NOT_READY;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.take_restart = 1'b1;
                        state_next       = S_SCAN_RD;
                    end
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_done)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/frq_dp.sv */
// Frame reorder queue datapath: slot memory, counters, scan/shift indexes,
// config register and the registered result stage. Depends on frq_pkg.
`timescale 1ns / 1ps

module frq_dp #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  frq_pkg::dp_cmd_t   cmd,
    output frq_pkg::dp_stat_t  stat,
    input  logic [1:0]         req_type,
    input  logic [15:0]        frame_handle,
    input  logic [23:0]        frame_size,
    input  logic signed [63:0] pts,
    input  logic signed [63:0] duration,
    input  logic               force_key,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_data,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output logic [1:0]         status,
    output logic [15:0]        out_handle,
    output logic [23:0]        out_size,
    output logic signed [63:0] out_pts,
    output logic signed [63:0] out_duration,
    output logic [31:0]        out_display_index,
    output logic [1:0]         frame_type,
    output logic               ref_frame,
    output logic [31:0]        anchor_disp,
    output logic               out_forced
);
    import frq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    slot_t mem [QUEUE_DEPTH];
    slot_t rd_data_reg;
    slot_t req_slot_reg;
    slot_t res_slot_reg;
    slot_t wr_data;

    req_code_t          req_code_reg;
    status_t            status_reg;
    logic               give_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [31:0]        next_disp_reg;
    logic [1:0]         max_b_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [CNT_W-1:0]   j_reg;
    logic               take_reg;
    logic               rsp_valid_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   j_prev;
    logic [CNT_W-1:0]   k_plus;
    frame_kind_t        res_kind;

    assign j_prev = j_reg - CNT_W'(1);
    assign k_plus = CNT_W'(k_reg) + CNT_W'(1);

    assign wr_en   = cmd.push_write | cmd.shift_wr;
    assign wr_addr = cmd.shift_wr ? j_prev[IDX_W-1:0] : count_reg[IDX_W-1:0];
    always_comb
    begin
        wr_data = req_slot_reg;
        wr_data.disp = next_disp_reg;
        if (cmd.shift_wr)
        begin
            wr_data = rd_data_reg;
        end
    end

    assign rd_en   = cmd.scan_rd | cmd.shift_rd;
    assign rd_addr = cmd.shift_rd ? j_reg[IDX_W-1:0] : k_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_slot_reg.handle   <= frame_handle;
            req_slot_reg.size     <= frame_size;
            req_slot_reg.pts      <= pts;
            req_slot_reg.duration <= duration;
            req_slot_reg.disp     <= 32'd0;
            req_slot_reg.forced   <= force_key;
        end
        if (cmd.capture)
        begin
            res_slot_reg <= rd_data_reg;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.load_out)
        begin
            status <= status_reg;
            if (give_reg)
            begin
                out_handle        <= res_slot_reg.handle;
                out_size          <= res_slot_reg.size;
                out_pts           <= res_slot_reg.pts;
                out_duration      <= res_slot_reg.duration;
                out_display_index <= res_slot_reg.disp;
                frame_type        <= res_kind;
                ref_frame         <= (res_kind != FT_B);
                anchor_disp       <= (res_kind == FT_B) ? res_slot_reg.disp + 32'd1
                                                        : res_slot_reg.disp;
                out_forced        <= res_slot_reg.forced;
            end
            else
            begin
                out_handle        <= '0;
                out_size          <= '0;
                out_pts           <= '0;
                out_duration      <= '0;
                out_display_index <= '0;
                frame_type        <= '0;
                ref_frame         <= 1'b0;
                anchor_disp       <= '0;
                out_forced        <= 1'b0;
            end
        end
    end

    assign res_kind = plan_type(res_slot_reg, max_b_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_code_reg  <= REQ_PUSH;
            give_reg      <= 1'b0;
            count_reg     <= '0;
            next_disp_reg <= '0;
            max_b_reg     <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            take_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_b_reg <= (cfg_data > MAX_B_LIMIT) ? MAX_B_LIMIT : cfg_data;
            end
            if (cmd.latch_req)
            begin
                req_code_reg <= req_code_t'(req_type);
                give_reg     <= 1'b0;
            end
            if (cmd.push_write)
            begin
                count_reg     <= count_reg + CNT_W'(1);
                next_disp_reg <= next_disp_reg + 32'd1;
            end
            if (cmd.count_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.scan_init)
            begin
                k_reg    <= '0;
                take_reg <= 1'b0;
            end
            if (cmd.take_restart)
            begin
                k_reg    <= '0;
                take_reg <= 1'b1;
            end
            if (cmd.k_inc)
            begin
                k_reg <= k_plus[IDX_W-1:0];
            end
            if (cmd.capture)
            begin
                give_reg <= 1'b1;
                j_reg    <= k_plus;
            end
            if (cmd.shift_wr)
            begin
                j_reg <= j_reg + CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;

    assign stat.req_code   = req_code_reg;
    assign stat.push_ok    = (req_slot_reg.size != 24'd0) &&
                             (count_reg != CNT_W'(QUEUE_DEPTH));
    assign stat.none_ready = (count_reg == '0) ||
                             (req_code_reg == REQ_POP && count_reg <= CNT_W'(max_b_reg));
    assign stat.take_hit   = take_reg || (plan_type(rd_data_reg, max_b_reg) != FT_B);
    assign stat.scan_last  = (k_plus == count_reg);
    assign stat.shift_done = (j_reg == count_reg);
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

endmodule
